@@ src/nsl_pkg.sv @@
`default_nettype none
package nsl_pkg;

  localparam int SEED_COUNT = 5;
  localparam int COORD_W    = 10;
  localparam int POS_W      = 2 * COORD_W;
  localparam int LABEL_W    = 3;
  localparam int IDX_W      = 3;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;

  localparam logic [LABEL_W-1:0] SEED_MARK = LABEL_W'(SEED_COUNT);
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [LABEL_W-1:0] label_t;

  typedef pos_t [SEED_COUNT-1:0] seed_arr_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic   valid;
    coord_t row;
    coord_t col;
    dist_t  best;
    label_t label;
    logic   on_seed;
  } cell_bus_t;

endpackage
`default_nettype wire

@@ src/nsl_pix_if.sv @@
`default_nettype none
interface nsl_pix_if;
  logic            valid;
  logic            ready;
  nsl_pkg::coord_t pixel_row;
  nsl_pkg::coord_t pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface
`default_nettype wire

@@ src/nsl_lbl_if.sv @@
`default_nettype none
interface nsl_lbl_if;
  logic            valid;
  logic            ready;
  nsl_pkg::label_t region_label;

  modport source (output valid, output region_label, input ready);
  modport sink   (input valid, input region_label, output ready);
endinterface
`default_nettype wire

@@ src/nearest_seed_labeler_top.sv @@
`default_nettype none
// Nearest-seed (Voronoi) labeler. Each pixel transfer on in_pix carries a row and
// column; the matching transfer on out_lbl carries the index (0..4) of the seed
// with the smallest exact squared Euclidean distance, the lowest index winning
// ties, or 5 when the pixel sits exactly on a seed. Seeds are written through
// cfg_we/cfg_index/cfg_data as row*1024+column, index 0..4; other indexes are
// ignored, and all seeds reset to (0,0). Write seeds only while no pixel is in
// flight. Throughput is one pixel per cycle while out_lbl does not stall; each
// pixel is registered in turn by every cell of the five-cell comparison chain
// (one cell per seed). The last cell's register is the output register; when
// out_lbl stalls the whole chain holds and in_pix.ready drops in the same cycle.
module nearest_seed_labeler_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  nsl_pix_if.sink                        in_pix,
  nsl_lbl_if.source                      out_lbl,
  input  wire logic                      cfg_we,
  input  wire logic [nsl_pkg::IDX_W-1:0] cfg_index,
  input  wire nsl_pkg::pos_t             cfg_data
);

  nsl_pkg::seed_arr_t seeds;
  nsl_pkg::cell_bus_t chain [nsl_pkg::SEED_COUNT+1];
  logic               advance;

  nsl_seed_bank u_seed_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seeds     (seeds)
  );

  // Advance the chain unless a finished label is waiting to be taken.
  assign advance      = !(chain[nsl_pkg::SEED_COUNT].valid && !out_lbl.ready);
  assign in_pix.ready = advance;

  // Head of the chain: best distance starts above any reachable value, so
  // the first cell always claims the pixel.
  always_comb begin
    chain[0].valid   = in_pix.valid;
    chain[0].row     = in_pix.pixel_row;
    chain[0].col     = in_pix.pixel_col;
    chain[0].best    = nsl_pkg::DIST_MAX;
    chain[0].label   = '0;
    chain[0].on_seed = 1'b0;
  end

  for (genvar k = 0; k < nsl_pkg::SEED_COUNT; k++) begin : g_cell
    nsl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .seed_pos (seeds[k]),
      .seed_idx (nsl_pkg::LABEL_W'(k)),
      .bus_in   (chain[k]),
      .bus_out  (chain[k+1])
    );
  end

  // Replace the index by the seed mark when the pixel hit a seed.
  assign out_lbl.valid        = chain[nsl_pkg::SEED_COUNT].valid;
  assign out_lbl.region_label = chain[nsl_pkg::SEED_COUNT].on_seed ?
                                nsl_pkg::SEED_MARK : chain[nsl_pkg::SEED_COUNT].label;

endmodule
`default_nettype wire

@@ src/nsl_seed_bank.sv @@
`default_nettype none
module nsl_seed_bank (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [nsl_pkg::IDX_W-1:0] cfg_index,
  input  wire nsl_pkg::pos_t            cfg_data,
  output nsl_pkg::seed_arr_t            seeds
);

  nsl_pkg::seed_arr_t seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we && (cfg_index < nsl_pkg::IDX_W'(nsl_pkg::SEED_COUNT))) begin
      // drop writes beyond the last seed
      seed_r[cfg_index] <= cfg_data;
    end
  end

  assign seeds = seed_r;

endmodule
`default_nettype wire

@@ src/nsl_cell.sv @@
`default_nettype none
module nsl_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire nsl_pkg::pos_t      seed_pos,
  input  wire nsl_pkg::label_t    seed_idx,
  input  wire nsl_pkg::cell_bus_t bus_in,
  output nsl_pkg::cell_bus_t      bus_out
);

  nsl_pkg::coord_t    seed_row;
  nsl_pkg::coord_t    seed_col;
  nsl_pkg::coord_t    dr;
  nsl_pkg::coord_t    dc;
  logic [nsl_pkg::SQ_W-1:0] dr_sq;
  logic [nsl_pkg::SQ_W-1:0] dc_sq;
  nsl_pkg::dist_t     sq_sum;
  nsl_pkg::cell_bus_t bus_nxt;
  nsl_pkg::cell_bus_t bus_r;

  assign seed_row = seed_pos[nsl_pkg::POS_W-1:nsl_pkg::COORD_W];
  assign seed_col = seed_pos[nsl_pkg::COORD_W-1:0];

  always_comb begin
    dr     = (bus_in.row >= seed_row) ? (bus_in.row - seed_row) : (seed_row - bus_in.row);
    dc     = (bus_in.col >= seed_col) ? (bus_in.col - seed_col) : (seed_col - bus_in.col);
    dr_sq  = dr * dr;
    dc_sq  = dc * dc;
    sq_sum = nsl_pkg::DIST_W'(dr_sq) + nsl_pkg::DIST_W'(dc_sq);

    bus_nxt = bus_in;
    // strictly smaller wins, so ties keep the lower index
    if (sq_sum < bus_in.best) begin
      bus_nxt.best  = sq_sum;
      bus_nxt.label = seed_idx;
    end
    if (sq_sum == '0) begin
      bus_nxt.on_seed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r.valid <= bus_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bus_r.row     <= bus_nxt.row;
      bus_r.col     <= bus_nxt.col;
      bus_r.best    <= bus_nxt.best;
      bus_r.label   <= bus_nxt.label;
      bus_r.on_seed <= bus_nxt.on_seed;
    end
  end

  assign bus_out = bus_r;

endmodule
`default_nettype wire

@@ src/nsl_checker.sv @@
`default_nettype none
module nsl_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire nsl_pkg::label_t region_label
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(region_label))
    else $error("stalled label changed or dropped");

  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> region_label <= nsl_pkg::SEED_MARK)
    else $error("label out of range");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output stall");

endmodule

bind nearest_seed_labeler_top nsl_checker u_nsl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_pix.ready),
  .out_valid    (out_lbl.valid),
  .out_ready    (out_lbl.ready),
  .region_label (out_lbl.region_label)
);
`default_nettype wire
